### rtl/rel_pkg.sv
// Shared types, constants and register indexes for the resistance emulation loop.
package rel_pkg;

    localparam int RES_BITS            = 24;
    localparam int ADC_SCALE_BITS_DEF  = 28;
    localparam int COUNTER_WIDTH_DEF   = 16;
    localparam int DRIVE_OUT_W         = 28;
    localparam int COUNT_OUT_W         = 16;
    localparam int DAC_WORD_W          = 22;
    localparam int DAC_SPAN_W          = 20;
    localparam int CFG_IDX_W           = 3;

    localparam logic [DAC_SPAN_W-1:0] DAC_SPAN = 20'hffff0;
    localparam logic [DAC_WORD_W-1:0] DAC_BASE = 22'h300000;

    localparam logic [RES_BITS-1:0] LOAD_RES_RST  = 24'd100000;
    localparam logic [RES_BITS-1:0] SENSE_RES_RST = 24'd100000;
    localparam int                  NOISE_RST     = 100;
    localparam int                  MIN_LEVEL_RST = 78294;
    localparam int                  DEADBAND_RST  = 22370;

    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_RES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSE_RES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GATE,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV,
        ST_TGT,
        ST_ERR,
        ST_CHECK,
        ST_ADD,
        ST_DAC_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic gate;
        logic mul;
        logic div_start;
        logic tgt;
        logic err;
        logic add;
        logic dac_mul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic gate_pass;
        logic div_done;
        logic err_pass;
        logic out_free;
    } t_sts;

endpackage

### rtl/rel_ctrl.sv
// Sequencer for one sample: gate, ratio, correction, DAC word, result hand-off.
module rel_ctrl
    import rel_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_GATE;
            ST_GATE:     n_state = i_sts.gate_pass ? ST_MUL : ST_DONE;
            ST_MUL:      n_state = ST_DIV_LOAD;
            ST_DIV_LOAD: n_state = ST_DIV;
            ST_DIV:      if (i_sts.div_done) n_state = ST_TGT;
            ST_TGT:      n_state = ST_ERR;
            ST_ERR:      n_state = ST_CHECK;
            ST_CHECK:    n_state = i_sts.err_pass ? ST_ADD : ST_DONE;
            ST_ADD:      n_state = ST_DAC_MUL;
            ST_DAC_MUL:  n_state = ST_DONE;
            ST_DONE:     if (i_sts.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_GATE:     o_cmd.gate      = 1'b1;
            ST_MUL:      o_cmd.mul       = 1'b1;
            ST_DIV_LOAD: o_cmd.div_start = 1'b1;
            ST_DIV:      ;
            ST_TGT:      o_cmd.tgt       = 1'b1;
            ST_ERR:      o_cmd.err       = 1'b1;
            ST_CHECK:    ;
            ST_ADD:      o_cmd.add       = 1'b1;
            ST_DAC_MUL:  o_cmd.dac_mul   = 1'b1;
            ST_DONE:     o_cmd.out_load  = i_sts.out_free;
            default:     ;
        endcase
    end

endmodule

### rtl/rel_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
module rel_div
    import rel_pkg::*;
#(
    parameter int NUM_W = ADC_SCALE_BITS_DEF + RES_BITS,
    parameter int DEN_W = RES_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int STEPS = (NUM_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [PAD_W-1:0] r_acc;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [PAD_W-1:0] n_acc;
    logic [DEN_W-1:0] n_rem;

    // shift the next dividend bit into the remainder, subtract when it fits
    always_comb begin
        logic [DEN_W:0] v_shift;
        n_acc = r_acc;
        n_rem = r_rem;
        for (int k = 0; k < 2; k++) begin
            v_shift = {n_rem, n_acc[PAD_W-1]};
            n_acc   = {n_acc[PAD_W-2:0], 1'b0};
            if (v_shift >= {1'b0, r_den}) begin
                v_shift  = v_shift - {1'b0, r_den};
                n_acc[0] = 1'b1;
            end
            n_rem = v_shift[DEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= PAD_W'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
        end
    end

    assign o_done = ~r_busy;
    assign o_quot = r_acc[NUM_W-1:0];

endmodule

### rtl/rel_datapath.sv
// Datapath: settings, sample gate, ratio multiply and divide, drive update, result register.
module rel_datapath
    import rel_pkg::*;
#(
    parameter int ADC_SCALE_BITS = ADC_SCALE_BITS_DEF,
    parameter int COUNTER_WIDTH  = COUNTER_WIDTH_DEF,
    parameter int CFG_W          = (ADC_SCALE_BITS > RES_BITS) ? ADC_SCALE_BITS : RES_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic signed [ADC_SCALE_BITS:0] i_sense_sample,
    input  logic signed [ADC_SCALE_BITS:0] i_reference_sample,
    input  t_cmd                         i_cmd,
    output t_sts                         o_sts,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_sample_accepted,
    output logic                         o_dac_update,
    output logic [DAC_WORD_W-1:0]        o_dac_word,
    output logic [DRIVE_OUT_W-1:0]       o_drive_level_out,
    output logic [COUNT_OUT_W-1:0]       o_update_count
);

    localparam int S        = ADC_SCALE_BITS;
    localparam int SAMPLE_W = S + 1;
    localparam int STEP_W   = S + 2;
    localparam int RATIO_W  = RES_BITS + 1;
    localparam int PROD_W   = SAMPLE_W + RATIO_W;
    localparam int MAG_W    = S + RES_BITS;
    localparam int TGT_W    = MAG_W + 1;
    localparam int ERR_W    = MAG_W + 2;
    localparam int NEXT_W   = ERR_W + 1;
    localparam int DACP_W   = S + DAC_SPAN_W;

    localparam logic [S-1:0] DRIVE_MAX   = S'((64'd1199 << S) / 64'd1200);
    localparam logic [S-1:0] DRIVE_RESET = S'(64'd1 << (S - 1));
    localparam logic signed [NEXT_W-1:0] DRIVE_MAX_EXT = NEXT_W'(DRIVE_MAX);

    // settings
    logic [RES_BITS-1:0] r_load_res;
    logic [RES_BITS-1:0] r_sense_res;
    logic [S-1:0]        r_noise;
    logic [S-1:0]        r_min_level;
    logic [S-1:0]        r_deadband;

    // loop state
    logic signed [SAMPLE_W-1:0] r_prev;
    logic [S-1:0]               r_drive;
    logic [COUNTER_WIDTH-1:0]   r_count;

    // per-sample working registers
    logic signed [SAMPLE_W-1:0] r_sense;
    logic signed [SAMPLE_W-1:0] r_ref;
    logic signed [STEP_W-1:0]   r_step;
    logic signed [RATIO_W-1:0]  r_ratio;
    logic [RES_BITS-1:0]        r_divisor;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_neg;
    logic signed [TGT_W-1:0]    r_target;
    logic signed [ERR_W-1:0]    r_err;
    logic [DACP_W-1:0]          r_dac_prod;
    logic                       r_accepted;
    logic                       r_updated;

    logic [STEP_W-1:0]         step_mag;
    logic [SAMPLE_W-1:0]       sense_mag;
    logic [ERR_W-1:0]          err_mag;
    logic [MAG_W-1:0]          prod_mag;
    logic [MAG_W-1:0]          quot;
    logic                      div_done;
    logic signed [NEXT_W-1:0]  drive_next;
    logic [S-1:0]              drive_clamped;
    logic [DAC_SPAN_W-1:0]     dac_code;
    logic [DAC_WORD_W-1:0]     dac_word;
    logic                      out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_res  <= LOAD_RES_RST;
            r_sense_res <= SENSE_RES_RST;
            r_noise     <= S'(NOISE_RST);
            r_min_level <= S'(MIN_LEVEL_RST);
            r_deadband  <= S'(DEADBAND_RST);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LOAD_RES:  r_load_res  <= RES_BITS'(i_cfg_data);
                CFG_SENSE_RES: r_sense_res <= RES_BITS'(i_cfg_data);
                CFG_NOISE:     r_noise     <= S'(i_cfg_data);
                CFG_MIN_LEVEL: r_min_level <= S'(i_cfg_data);
                CFG_DEADBAND:  r_deadband  <= S'(i_cfg_data);
                default:       ;
            endcase
        end
    end

    assign step_mag  = r_step[STEP_W-1] ? (~r_step + 1'b1) : r_step;
    assign sense_mag = r_sense[SAMPLE_W-1] ? (~r_sense + 1'b1) : r_sense;
    assign err_mag   = r_err[ERR_W-1] ? (~r_err + 1'b1) : r_err;
    assign prod_mag  = r_prod[PROD_W-1] ? MAG_W'(~r_prod + 1'b1) : MAG_W'(r_prod);

    rel_div #(
        .NUM_W (MAG_W),
        .DEN_W (RES_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (prod_mag),
        .i_den   (r_divisor),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign drive_next = $signed(NEXT_W'({1'b0, r_drive})) + NEXT_W'(r_err);

    always_comb begin
        priority if (drive_next > DRIVE_MAX_EXT) begin
            drive_clamped = DRIVE_MAX;
        end else if (drive_next[NEXT_W-1]) begin
            drive_clamped = '0;
        end else begin
            drive_clamped = drive_next[S-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= '0;
            r_drive    <= DRIVE_RESET;
            r_count    <= '0;
            r_accepted <= 1'b0;
            r_updated  <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_prev <= i_sense_sample;
            end
            if (i_cmd.gate) begin
                r_accepted <= o_sts.gate_pass;
                r_updated  <= 1'b0;
            end
            if (i_cmd.add) begin
                r_drive   <= drive_clamped;
                r_count   <= r_count + 1'b1;
                r_updated <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sense   <= i_sense_sample;
            r_ref     <= i_reference_sample;
            r_step    <= STEP_W'(i_sense_sample) - STEP_W'(r_prev);
            r_ratio   <= $signed({1'b0, r_load_res}) - $signed({1'b0, r_sense_res});
            // a zero sense resistance divides by one
            r_divisor <= (r_sense_res == '0) ? RES_BITS'(1) : r_sense_res;
        end
        if (i_cmd.mul) begin
            r_prod <= r_sense * r_ratio;
        end
        if (i_cmd.div_start) begin
            r_neg <= r_prod[PROD_W-1];
        end
        if (i_cmd.tgt) begin
            r_target <= r_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
        end
        if (i_cmd.err) begin
            r_err <= ERR_W'(r_target) - ERR_W'(r_ref);
        end
        if (i_cmd.dac_mul) begin
            r_dac_prod <= DACP_W'(r_drive) * DACP_W'(DAC_SPAN);
        end
    end

    assign dac_code = DAC_SPAN_W'(r_dac_prod >> S) & DAC_SPAN;
    assign dac_word = r_updated ? (DAC_BASE + DAC_WORD_W'(dac_code)) : '0;

    // output stage: hold the result until the transaction completes
    assign out_free = ~o_out_valid | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_sample_accepted <= r_accepted;
            o_dac_update      <= r_updated;
            o_dac_word        <= dac_word;
            o_drive_level_out <= DRIVE_OUT_W'(r_drive);
            o_update_count    <= COUNT_OUT_W'(r_count);
        end
    end

    assign o_sts.gate_pass = (step_mag < STEP_W'(r_noise)) && (sense_mag >= SAMPLE_W'(r_min_level));
    assign o_sts.div_done  = div_done;
    assign o_sts.err_pass  = err_mag >= ERR_W'(r_deadband);
    assign o_sts.out_free  = out_free;

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive <= DRIVE_MAX)
        else $error("drive level above clamp");

    a_update_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dac_update |-> o_sample_accepted)
        else $error("DAC update without accepted sample");

    a_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_dac_update |-> o_dac_word == '0)
        else $error("DAC word set without update");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add |=> r_count == $past(r_count) + 1'b1)
        else $error("update counter did not advance");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("result overwritten before transaction");

endmodule

### rtl/resistance_emulation_loop_top.sv
// Top level of the resistance emulation loop: controller plus datapath.
// Each transaction on the input carries a sense and a reference conversion; exactly one
// result follows per input. A sample that fails the noise/level gate goes straight to the
// result; an accepted sample passes the ratio multiply and divide and is corrected only
// when its error magnitude reaches the deadband. The divider retires two quotient bits
// per cycle. The next input is taken in the cycle after the result is loaded. One sample
// is processed at a time; the next input is taken while the previous result still waits
// in the output register, and the new result is held back until that transaction
// completes. Settings reset to 100000 mohm, 100000 mohm, 100, 78294 and 22370. The user
// must see that they are written only while idle; the block itself does not enforce this.
module resistance_emulation_loop_top
    import rel_pkg::*;
#(
    parameter int ADC_SCALE_BITS = ADC_SCALE_BITS_DEF,
    parameter int COUNTER_WIDTH  = COUNTER_WIDTH_DEF,
    parameter int CFG_W          = (ADC_SCALE_BITS > RES_BITS) ? ADC_SCALE_BITS : RES_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]               i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [ADC_SCALE_BITS:0] i_sense_sample,
    input  logic signed [ADC_SCALE_BITS:0] i_reference_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_sample_accepted,
    output logic                           o_dac_update,
    output logic [DAC_WORD_W-1:0]          o_dac_word,
    output logic [DRIVE_OUT_W-1:0]         o_drive_level_out,
    output logic [COUNT_OUT_W-1:0]         o_update_count
);

    t_cmd cmd;
    t_sts sts;

    rel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rel_datapath #(
        .ADC_SCALE_BITS (ADC_SCALE_BITS),
        .COUNTER_WIDTH  (COUNTER_WIDTH),
        .CFG_W          (CFG_W)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_sense_sample     (i_sense_sample),
        .i_reference_sample (i_reference_sample),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_sample_accepted  (o_sample_accepted),
        .o_dac_update       (o_dac_update),
        .o_dac_word         (o_dac_word),
        .o_drive_level_out  (o_drive_level_out),
        .o_update_count     (o_update_count)
    );

endmodule
